// File: hdl/top_k_cosine_similarity_search_unit_macros.svh
// Assertion macros for the top-k cosine similarity search unit.
// Used by the port checker; needs a clock named clk and a reset named rst_n.
`ifndef TOP_K_COSINE_SIMILARITY_SEARCH_UNIT_MACROS_SVH
`define TOP_K_COSINE_SIMILARITY_SEARCH_UNIT_MACROS_SVH

`define TKCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkcs check failed");

`define TKCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkcs check failed");

`define TKCS_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tkcs check failed");

`endif

// File: hdl/tkcs_pkg.sv
// Shared constants, item types and command codes of the search unit.
// No dependencies.
`timescale 1ns / 1ps
package tkcs_pkg;
  localparam int DIM_MAX = 512;
  localparam int K_MAX = 16;
  localparam int ELEM_W = 16;
  localparam int ID_W = 16;
  localparam int SIM_W = 16;
  localparam int IDX_W = $clog2(DIM_MAX + 1);
  localparam int ADDR_W = $clog2(DIM_MAX);
  localparam int K_W = $clog2(K_MAX + 1);
  localparam int RANK_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int SQ_W = 41;
  localparam int DOT_W = 42;
  localparam int ROOT_W = 24;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int DEN_W = 2 * ROOT_W;
  localparam int NUM_W = DOT_W + 21;
  localparam int RC_W = 5;
  localparam int VS_W = 17;
  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE = 1'd1;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_CAND = 1'b1;

  localparam logic signed [SIM_W-1:0] SIM_UNFILLED = 16'sh8000;
  localparam logic signed [SIM_W-1:0] SIM_TOP = 16'sh7FFF;

  typedef struct packed {
    logic command;
    logic signed [ELEM_W-1:0] element_value;
    logic [ID_W-1:0] word_id;
    logic last_element;
    logic last_candidate;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] match_id;
    logic signed [SIM_W-1:0] similarity;
    logic filled;
    logic last_result;
  } out_item_t;

  typedef struct packed {
    logic is_cand;
    logic new_query;
    logic close_query;
    logic last_el;
    logic last_cand;
    logic signed [ELEM_W-1:0] value;
    logic [ID_W-1:0] id;
  } op_t;
endpackage

// File: hdl/tkcs_item_if.sv
// Valid/ready channel interfaces for input and result items.
// Depends on tkcs_pkg.
`timescale 1ns / 1ps
interface tkcs_in_if;
  logic valid;
  logic ready;
  tkcs_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tkcs_out_if;
  logic valid;
  logic ready;
  tkcs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/tkcs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tkcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

// File: hdl/tkcs_front.sv
// Front end: accepts items and classifies them into operations.
// Depends on tkcs_pkg and tkcs_item_if.
`timescale 1ns / 1ps
module tkcs_front (
  input  logic          clk,
  input  logic          rst_n,
  tkcs_in_if.sink       in_item,
  input  logic          q_ready,
  output logic          q_push,
  output tkcs_pkg::op_t q_op
);
  import tkcs_pkg::*;

  logic open_r;
  logic is_cand;

  assign is_cand = (in_item.payload.command == CMD_CAND);
  assign in_item.ready = q_ready;
  assign q_push = in_item.valid && q_ready;

  always_comb begin
    q_op.is_cand = is_cand;
    q_op.new_query = !is_cand && !open_r;
    q_op.close_query = is_cand && open_r;
    q_op.last_el = in_item.payload.last_element;
    q_op.last_cand = is_cand && in_item.payload.last_element
                     && in_item.payload.last_candidate;
    q_op.value = in_item.payload.element_value;
    q_op.id = in_item.payload.word_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (q_push) begin
      open_r <= !is_cand && !in_item.payload.last_element;
    end
  end
endmodule

// File: hdl/tkcs_queue.sv
// Short operation queue between the front end and the engine.
// Depends on tkcs_pkg.
`timescale 1ns / 1ps
module tkcs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tkcs_pkg::op_t push_op,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output tkcs_pkg::op_t head_op
);
  import tkcs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] count_r;

  assign ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head_op = mem_r[head_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_op;
    end
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + PTR_W'(1);
      end
      if (pop) begin
        head_r <= head_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end
endmodule

// File: hdl/tkcs_back.sv
// Engine: query store, accumulation, norms, quotient, top list and results.
// Depends on tkcs_pkg, tkcs_item_if and tkcs_ram.
`timescale 1ns / 1ps
module tkcs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tkcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tkcs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           q_valid,
  input  tkcs_pkg::op_t                  q_op,
  output logic                           q_pop,
  tkcs_out_if.source                     out_item
);
  import tkcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_FIN, S_SQRT, S_MUL, S_DIV, S_INS, S_EMIT
  } state_t;

  state_t state_r;
  op_t op_r;
  logic [RC_W-1:0] rc_r;
  logic [VS_W-1:0] vs_r;
  logic [IDX_W-1:0] idx_r, qlen_r;
  logic [SQ_W-1:0] qq_r, cc_r;
  logic [DOT_W-1:0] dot_r;
  logic [ID_W-1:0] top_id_r [K_MAX];
  logic signed [SIM_W-1:0] top_sc_r [K_MAX];
  logic top_fl_r [K_MAX];
  logic sq_sel_r;
  logic [RAD_W-1:0] sq_x_r;
  logic [REM_W-1:0] sq_rem_r;
  logic [ROOT_W-1:0] sq_res_r, nq_r;
  logic [5:0] cnt_r;
  logic [DEN_W-1:0] den_r, dv_rem_r;
  logic [NUM_W-1:0] num_r;
  logic neg_r, ovf_r;
  logic [SIM_W-1:0] quo_r;
  logic [RANK_W-1:0] rank_r;
  logic out_valid_r;
  out_item_t out_r;

  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ELEM_W-1:0] ram_rdata;
  logic [IDX_W-1:0] base_idx;
  logic [SQ_W-1:0] base_qq;
  logic signed [2*ELEM_W-1:0] op_sq, r_sq, dot_prod;
  logic [REM_W+1:0] sq_rem2, sq_trial;
  logic [DEN_W:0] dv_rem2;
  logic [DOT_W-1:0] mag;
  logic signed [SIM_W-1:0] sim;
  logic [K_W-1:0] k;
  logic do_ins;
  logic ge [K_MAX];
  logic at_pos [K_MAX];
  logic shift_dn [K_MAX];

  function automatic logic [K_W-1:0] eff_k(logic [RC_W-1:0] rc, logic [VS_W-1:0] vs);
    logic [VS_W-1:0] kk;
    kk = (rc > RC_W'(K_MAX)) ? VS_W'(K_MAX) : VS_W'(rc);
    if (vs <= VS_W'(1)) begin
      return '0;
    end
    if (kk >= vs) begin
      kk = vs - VS_W'(1);
    end
    return kk[K_W-1:0];
  endfunction

  assign k = eff_k(rc_r, vs_r);
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign base_idx = q_op.is_cand ? (q_op.close_query ? '0 : idx_r)
                                 : (q_op.new_query ? '0 : idx_r);
  assign base_qq = q_op.new_query ? '0 : qq_r;
  assign ram_we = q_pop && !q_op.is_cand && (base_idx < IDX_W'(DIM_MAX));
  assign ram_addr = base_idx[ADDR_W-1:0];
  assign op_sq = q_op.value * q_op.value;
  assign r_sq = op_r.value * op_r.value;
  assign dot_prod = $signed(ram_rdata) * op_r.value;

  tkcs_ram #(.WIDTH(ELEM_W), .DEPTH(DIM_MAX)) u_query_store (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(q_op.value), .rdata(ram_rdata)
  );

  assign sq_rem2 = {sq_rem_r, sq_x_r[RAD_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_res_r, 2'b01};
  assign dv_rem2 = {dv_rem_r, num_r[NUM_W-1]};
  assign mag = dot_r[DOT_W-1] ? (~dot_r + DOT_W'(1)) : dot_r;

  always_comb begin
    if (neg_r) begin
      sim = (ovf_r || quo_r[SIM_W-1]) ? SIM_UNFILLED : -$signed(quo_r);
    end else begin
      sim = (ovf_r || quo_r >= SIM_W'(SIM_TOP)) ? SIM_TOP : $signed(quo_r);
    end
  end

  always_comb begin
    do_ins = (k != '0) && (sim > top_sc_r[RANK_W'(k - K_W'(1))]);
    for (int j = 0; j < K_MAX; j++) begin
      ge[j] = (top_sc_r[j] >= sim);
    end
    for (int j = 0; j < K_MAX; j++) begin
      at_pos[j] = (K_W'(j) < k) && !ge[j] && ((j == 0) || ge[(j == 0) ? 0 : j - 1]);
      shift_dn[j] = (K_W'(j) < k) && !ge[j] && !at_pos[j];
    end
  end

  assign out_item.valid = out_valid_r;
  assign out_item.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rc_r <= RC_W'(1);
      vs_r <= VS_W'(65536);
      idx_r <= '0;
      qlen_r <= '0;
      qq_r <= '0;
      cc_r <= '0;
      dot_r <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < K_MAX; j++) begin
        top_id_r[j] <= '0;
        top_sc_r[j] <= SIM_UNFILLED;
        top_fl_r[j] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RESULT_COUNT: rc_r <= cfg_data[RC_W-1:0];
          CFG_VOCAB_SIZE: vs_r <= cfg_data[VS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r <= q_op;
            if (!q_op.is_cand) begin
              if (q_op.new_query) begin
                dot_r <= '0;
                cc_r <= '0;
                qlen_r <= '0;
                for (int j = 0; j < K_MAX; j++) begin
                  top_id_r[j] <= '0;
                  top_sc_r[j] <= SIM_UNFILLED;
                  top_fl_r[j] <= 1'b0;
                end
              end
              if (base_idx < IDX_W'(DIM_MAX)) begin
                qq_r <= base_qq + {{(SQ_W-2*ELEM_W){1'b0}}, op_sq};
                if (q_op.last_el) begin
                  qlen_r <= base_idx + IDX_W'(1);
                  idx_r <= '0;
                end else begin
                  idx_r <= base_idx + IDX_W'(1);
                end
              end else begin
                qq_r <= base_qq;
                if (q_op.last_el) begin
                  qlen_r <= base_idx;
                end
                idx_r <= q_op.last_el ? '0 : base_idx;
              end
            end else begin
              if (q_op.close_query) begin
                qlen_r <= idx_r;
              end
              idx_r <= base_idx;
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (idx_r < qlen_r) begin
            dot_r <= dot_r + {{(DOT_W-2*ELEM_W){dot_prod[2*ELEM_W-1]}}, dot_prod};
            cc_r <= cc_r + {{(SQ_W-2*ELEM_W){1'b0}}, r_sq};
          end
          if (idx_r < IDX_W'(DIM_MAX)) begin
            idx_r <= idx_r + IDX_W'(1);
          end
          state_r <= op_r.last_el ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (qq_r == '0 || cc_r == '0) begin
            dot_r <= '0;
            cc_r <= '0;
            idx_r <= '0;
            rank_r <= '0;
            state_r <= (op_r.last_cand && k != '0) ? S_EMIT : S_IDLE;
          end else begin
            sq_sel_r <= 1'b0;
            sq_x_r <= {1'b0, qq_r, 6'b0};
            sq_rem_r <= '0;
            sq_res_r <= '0;
            cnt_r <= 6'(ROOT_W - 1);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_x_r <= {sq_x_r[RAD_W-3:0], 2'b00};
          if (sq_rem2 >= sq_trial) begin
            sq_rem_r <= REM_W'(sq_rem2 - sq_trial);
            sq_res_r <= {sq_res_r[ROOT_W-2:0], 1'b1};
          end else begin
            sq_rem_r <= sq_rem2[REM_W-1:0];
            sq_res_r <= {sq_res_r[ROOT_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            if (!sq_sel_r) begin
              nq_r <= (sq_rem2 >= sq_trial) ? {sq_res_r[ROOT_W-2:0], 1'b1}
                                            : {sq_res_r[ROOT_W-2:0], 1'b0};
              sq_sel_r <= 1'b1;
              sq_x_r <= {1'b0, cc_r, 6'b0};
              sq_rem_r <= '0;
              sq_res_r <= '0;
              cnt_r <= 6'(ROOT_W - 1);
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          den_r <= nq_r * sq_res_r;
          neg_r <= dot_r[DOT_W-1];
          num_r <= {mag, 21'b0};
          dv_rem_r <= '0;
          quo_r <= '0;
          ovf_r <= 1'b0;
          cnt_r <= 6'(NUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          num_r <= {num_r[NUM_W-2:0], 1'b0};
          ovf_r <= ovf_r | quo_r[SIM_W-1];
          if (dv_rem2 >= {1'b0, den_r}) begin
            dv_rem_r <= DEN_W'(dv_rem2 - {1'b0, den_r});
            quo_r <= {quo_r[SIM_W-2:0], 1'b1};
          end else begin
            dv_rem_r <= dv_rem2[DEN_W-1:0];
            quo_r <= {quo_r[SIM_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == '0) begin
            state_r <= S_INS;
          end
        end
        S_INS: begin
          if (do_ins) begin
            for (int j = 0; j < K_MAX; j++) begin
              if (at_pos[j]) begin
                top_id_r[j] <= op_r.id;
                top_sc_r[j] <= sim;
                top_fl_r[j] <= 1'b1;
              end else if (shift_dn[j] && j > 0) begin
                top_id_r[j] <= top_id_r[(j > 0) ? j - 1 : 0];
                top_sc_r[j] <= top_sc_r[(j > 0) ? j - 1 : 0];
                top_fl_r[j] <= top_fl_r[(j > 0) ? j - 1 : 0];
              end
            end
          end
          dot_r <= '0;
          cc_r <= '0;
          idx_r <= '0;
          rank_r <= '0;
          state_r <= (op_r.last_cand && k != '0) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_valid_r || out_item.ready) begin
            out_valid_r <= 1'b1;
            out_r.match_id <= top_id_r[rank_r];
            out_r.similarity <= top_sc_r[rank_r];
            out_r.filled <= top_fl_r[rank_r];
            out_r.last_result <= (K_W'(rank_r) + K_W'(1) == k);
            rank_r <= rank_r + RANK_W'(1);
            if (K_W'(rank_r) + K_W'(1) == k) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/top_k_cosine_similarity_search_unit.sv
// Top-k cosine similarity search: query elements are stored, candidate elements are
// read back and accumulated, and a candidate's last element adds a norm check, two
// serial square roots, a product and a bit-serial quotient, or only the norm check
// when a norm is zero. k results follow at one per cycle while the output is ready, and
// items wait in a four-entry queue. Synchronous active-low reset clears the queue,
// accumulators and top list and resets the configuration; the query store is not cleared.
`timescale 1ns / 1ps
module top_k_cosine_similarity_search_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  tkcs_in_if.sink                        in_item,
  tkcs_out_if.source                     out_item,
  input  logic                           cfg_we,
  input  logic [tkcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tkcs_pkg::CFG_W-1:0]     cfg_data
);
  import tkcs_pkg::*;

  logic q_ready, q_push, q_valid, q_pop;
  op_t push_op, head_op;

  tkcs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_item(in_item),
    .q_ready(q_ready), .q_push(q_push), .q_op(push_op)
  );

  tkcs_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_op(push_op), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .head_op(head_op)
  );

  tkcs_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_valid(q_valid), .q_op(head_op), .q_pop(q_pop),
    .out_item(out_item)
  );
endmodule

// File: hdl/tkcs_checker.sv
// Port checker for the search unit, bound to the top level.
// Depends on tkcs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "top_k_cosine_similarity_search_unit_macros.svh"
module tkcs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tkcs_pkg::ID_W-1:0]          out_match_id,
  input logic signed [tkcs_pkg::SIM_W-1:0]  out_similarity,
  input logic                               out_filled,
  input logic                               out_last_result
);
  import tkcs_pkg::*;

  logic [ID_W+SIM_W+1:0] out_bits;

  assign out_bits = {out_match_id, out_similarity, out_filled, out_last_result};

  `TKCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bits))
  `TKCS_ASSERT_NOW(a_unfilled_score, out_valid && !out_filled, out_similarity == SIM_UNFILLED && out_match_id == '0)
  `TKCS_ASSERT_NOW(a_filled_score, out_valid && out_filled, out_similarity != SIM_UNFILLED)
  `TKCS_ASSERT_RESET(a_reset_quiet, !rst_n, !out_valid)
endmodule

bind top_k_cosine_similarity_search_unit tkcs_checker u_tkcs_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_item.valid), .out_ready(out_item.ready),
  .out_match_id(out_item.payload.match_id),
  .out_similarity(out_item.payload.similarity),
  .out_filled(out_item.payload.filled),
  .out_last_result(out_item.payload.last_result)
);
